// File: hw/rtl/sfr_pkg.sv
// sfr_pkg: shared constants, types and helpers for the stream find-and-replace block.
// Depends on nothing; every other file of the block but sfr_checker imports it.
`default_nettype none

package sfr_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int REPLACE_MAX = 16;
    localparam int LEN_W       = 5;                   // holds 0..16
    localparam int IDX_W       = $clog2(PATTERN_MAX); // byte index into window or strings
    localparam int STR_W       = 128;                 // two 64-bit registers of bytes
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int COUNT_W     = 32;

    // Register map, 8-byte stride
    typedef enum logic [2:0] {
        REG_PATTERN_LO  = 3'd0,
        REG_PATTERN_HI  = 3'd1,
        REG_PATTERN_LEN = 3'd2,
        REG_REPLACE_LO  = 3'd3,
        REG_REPLACE_HI  = 3'd4,
        REG_REPLACE_LEN = 3'd5
    } reg_idx_t;

    // Configuration as used by the datapath, lengths already clamped
    typedef struct packed {
        logic [STR_W-1:0] pattern;
        logic [LEN_W-1:0] plen;
        logic [STR_W-1:0] replace;
        logic [LEN_W-1:0] rlen;
    } cfg_t;

    // Beat plan for one input byte, handed from the window to the emitter
    typedef struct packed {
        logic             lead_valid; // oldest byte passes through first
        logic [7:0]       lead_byte;
        logic             from_repl;  // remaining beats come from the replacement
        logic [LEN_W-1:0] count;      // beats read from replacement or window
        logic             eot;
        logic             bare;       // end marker with no byte at all
    } plan_t;

    function automatic logic [7:0] byte_at(input logic [STR_W-1:0] v,
                                           input logic [IDX_W-1:0] i);
        byte_at = v[{i, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sfr_cfg.sv
// sfr_cfg: APB register file holding pattern and replacement strings and lengths.
// Depends on sfr_pkg.
`default_nettype none

module sfr_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [sfr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output sfr_pkg::cfg_t                        cfg
);
    import sfr_pkg::*;

    logic [CFG_DATA_W-1:0] pat_lo_reg, pat_hi_reg, rep_lo_reg, rep_hi_reg;
    logic [LEN_W-1:0]      plen_reg, rlen_reg;
    logic                  wr_en;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            plen_reg   <= LEN_W'(1);
            rep_lo_reg <= '0;
            rep_hi_reg <= '0;
            rlen_reg   <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_PATTERN_LO:  pat_lo_reg <= pwdata;
                REG_PATTERN_HI:  pat_hi_reg <= pwdata;
                REG_PATTERN_LEN: plen_reg   <= pwdata[LEN_W-1:0];
                REG_REPLACE_LO:  rep_lo_reg <= pwdata;
                REG_REPLACE_HI:  rep_hi_reg <= pwdata;
                REG_REPLACE_LEN: rlen_reg   <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PATTERN_LO:  prdata = pat_lo_reg;
            REG_PATTERN_HI:  prdata = pat_hi_reg;
            REG_PATTERN_LEN: prdata = CFG_DATA_W'(plen_reg);
            REG_REPLACE_LO:  prdata = rep_lo_reg;
            REG_REPLACE_HI:  prdata = rep_hi_reg;
            REG_REPLACE_LEN: prdata = CFG_DATA_W'(rlen_reg);
            default:         prdata = '0;
        endcase
    end

    // Zero pattern length acts as one; both lengths saturate at their maxima
    always_comb begin
        cfg.pattern = {pat_hi_reg, pat_lo_reg};
        cfg.replace = {rep_hi_reg, rep_lo_reg};
        if (plen_reg == '0)
            cfg.plen = LEN_W'(1);
        else if (plen_reg > LEN_W'(PATTERN_MAX))
            cfg.plen = LEN_W'(PATTERN_MAX);
        else
            cfg.plen = plen_reg;
        if (rlen_reg > LEN_W'(REPLACE_MAX))
            cfg.rlen = LEN_W'(REPLACE_MAX);
        else
            cfg.rlen = rlen_reg;
    end

endmodule

`default_nettype wire

// File: hw/rtl/sfr_window.sv
// sfr_window: input register, window of pending bytes and the match decision.
// Depends on sfr_pkg; hands a beat plan per byte to sfr_emit.
`default_nettype none

module sfr_window (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_byte,
    input  wire logic                        s_eot,
    input  sfr_pkg::cfg_t                    cfg,
    output logic                             plan_valid,
    input  wire logic                        plan_ready,
    output sfr_pkg::plan_t                   plan,
    input  wire logic [sfr_pkg::IDX_W-1:0]   rd_idx,
    output logic      [7:0]                  rd_byte
);
    import sfr_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_eot_reg;
    logic [7:0]       win_reg  [PATTERN_MAX];
    logic [7:0]       win_next [PATTERN_MAX];
    logic [7:0]       w_ext    [PATTERN_MAX];
    logic [LEN_W-1:0] fill_reg, fill_next, fill_inc;
    logic             consume, match, pass;
    logic [PATTERN_MAX-1:0] eq;

    assign consume    = in_valid_reg & plan_ready;
    assign s_ready    = ~in_valid_reg | plan_ready;
    assign plan_valid = in_valid_reg;
    assign rd_byte    = win_reg[rd_idx];
    assign fill_inc   = fill_reg + LEN_W'(1);

    // Window with the new byte appended at the fill position
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_ext[i] = (LEN_W'(i) == fill_reg) ? in_byte_reg : win_reg[i];
            eq[i]    = (LEN_W'(i) >= cfg.plen) ||
                       (w_ext[i] == byte_at(cfg.pattern, IDX_W'(i)));
        end
    end

    assign match = (fill_inc == cfg.plen) & (&eq);
    assign pass  = ~match & (fill_inc >= cfg.plen);

    always_comb begin
        plan.lead_valid = pass;
        plan.lead_byte  = w_ext[0];
        plan.from_repl  = match;
        plan.eot        = in_eot_reg;
        plan.bare       = in_eot_reg & match & (cfg.rlen == '0);
        if (match)
            plan.count = cfg.rlen;
        else if (in_eot_reg)
            plan.count = pass ? fill_reg : fill_inc;
        else
            plan.count = '0;
    end

    always_comb begin
        for (int i = 0; i < PATTERN_MAX - 1; i++)
            win_next[i] = pass ? w_ext[i+1] : w_ext[i];
        win_next[PATTERN_MAX-1] = w_ext[PATTERN_MAX-1];
        if (match | in_eot_reg)
            fill_next = '0;
        else if (pass)
            fill_next = fill_reg;
        else
            fill_next = fill_inc;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid & s_ready)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            fill_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (consume)
                fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid & s_ready) begin
            in_byte_reg <= s_byte;
            in_eot_reg  <= s_eot;
        end
        if (consume)
            win_reg <= win_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/sfr_emit.sv
// sfr_emit: walks a beat plan into the output register, one beat per cycle
// while it is free. Depends on sfr_pkg; reads window bytes from sfr_window.
`default_nettype none

module sfr_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          plan_valid,
    output logic                               plan_ready,
    input  sfr_pkg::plan_t                     plan,
    input  sfr_pkg::cfg_t                      cfg,
    output logic      [sfr_pkg::IDX_W-1:0]     rd_idx,
    input  wire logic [7:0]                    rd_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [7:0]                    m_byte,
    output logic                               m_has_byte,
    output logic                               m_run_last,
    output logic                               m_stream_end,
    output logic      [sfr_pkg::COUNT_W-1:0]   m_total
);
    import sfr_pkg::*;

    logic               lead_valid_reg;
    logic [7:0]         lead_byte_reg;
    logic               from_repl_reg, eot_reg, bare_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   remain_reg;
    logic [COUNT_W-1:0] count_reg, total_next;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_has_reg, out_last_reg, out_end_reg;
    logic [COUNT_W-1:0] out_total_reg;

    logic       active, out_free, fire, load;
    logic [7:0] beat_byte;
    logic       beat_has, beat_last;

    assign active     = lead_valid_reg | (remain_reg != '0) | bare_reg;
    assign out_free   = ~out_valid_reg | m_ready;
    assign fire       = active & out_free;
    assign plan_ready = ~active | (fire & beat_last);
    assign load       = plan_valid & plan_ready;
    assign rd_idx     = idx_reg;

    always_comb begin
        if (lead_valid_reg) begin
            beat_byte = lead_byte_reg;
            beat_has  = 1'b1;
            beat_last = (remain_reg == '0);
        end else if (remain_reg != '0) begin
            beat_byte = from_repl_reg ? byte_at(cfg.replace, idx_reg) : rd_byte;
            beat_has  = 1'b1;
            beat_last = (remain_reg == LEN_W'(1));
        end else begin
            beat_byte = 8'h00;
            beat_has  = 1'b0;
            beat_last = 1'b1;
        end
    end

    assign total_next = count_reg + COUNT_W'(beat_has);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_valid_reg <= 1'b0;
            remain_reg     <= '0;
            bare_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (load) begin
                lead_valid_reg <= plan.lead_valid;
                remain_reg     <= plan.count;
                bare_reg       <= plan.bare;
            end else if (fire) begin
                if (lead_valid_reg)
                    lead_valid_reg <= 1'b0;
                else if (remain_reg != '0)
                    remain_reg <= remain_reg - LEN_W'(1);
                else
                    bare_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                count_reg     <= (beat_last & eot_reg) ? '0 : total_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lead_byte_reg <= plan.lead_byte;
            from_repl_reg <= plan.from_repl;
            eot_reg       <= plan.eot;
            idx_reg       <= '0;
        end else if (fire & ~lead_valid_reg & (remain_reg != '0)) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (fire) begin
            out_byte_reg  <= beat_byte;
            out_has_reg   <= beat_has;
            out_last_reg  <= beat_last;
            out_end_reg   <= beat_last & eot_reg;
            out_total_reg <= total_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_byte       = out_byte_reg;
    assign m_has_byte   = out_has_reg;
    assign m_run_last   = out_last_reg;
    assign m_stream_end = out_end_reg;
    assign m_total      = out_total_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stream_find_replace.sv
// stream_find_replace: top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_cfg, sfr_window and sfr_emit.
`default_nettype none

// Rewrites a byte text, replacing every leftmost non-overlapping occurrence of
// a 1..16 byte pattern with a 0..16 byte replacement. Bytes enter on the s_
// stream, s_tlast marking the last byte of a text. Each input beat is held in
// an input register, compared combinationally against the window of pending
// bytes, and turned into a short plan of output beats. The emitter sends one
// beat per cycle from that plan while the output is not stalled: the oldest
// window byte when it cannot start a match, the replacement string on a match,
// the rest of the window at the end of the text, or a bare end beat (no byte)
// when the last input gives nothing. Plain text streams at one byte per cycle
// while the output is not stalled; a beat yielding more than one output beat,
// as a match or the end of a text may, holds the input side until its plan is
// sent. The output is registered, so a stalled m_ side does not stop the next
// input beat from being taken into the input register. An input beat passes
// the input register, the plan registers of the emitter and the output
// register. m_tdata[39:8] carries the running count of bytes emitted in the
// current text; it is final on the beat with stream_end set, and restarts at
// zero for the next text. Registers are written through the APB port at byte
// address 8*i and take effect at once; write them only while the block is idle.
module stream_find_replace (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // [7:0] in_byte
    input  wire logic                            s_tlast,  // end_of_text
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [39:0]                     m_tdata,  // [7:0] out_byte, [39:8] total_length
    output logic                                 m_tlast,  // run_last
    output logic      [1:0]                      m_tuser,  // [0] has_byte, [1] stream_end
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [sfr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import sfr_pkg::*;

    cfg_t               cfg;
    plan_t              plan;
    logic               plan_valid, plan_ready;
    logic [IDX_W-1:0]   rd_idx;
    logic [7:0]         rd_byte;
    logic [7:0]         out_byte;
    logic               has_byte, stream_end;
    logic [COUNT_W-1:0] total;

    sfr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Window and match decision: one plan per input beat
    sfr_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_byte     (s_tdata),
        .s_eot      (s_tlast),
        .cfg        (cfg),
        .plan_valid (plan_valid),
        .plan_ready (plan_ready),
        .plan       (plan),
        .rd_idx     (rd_idx),
        .rd_byte    (rd_byte)
    );

    // Plan walker and output register
    sfr_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .plan_valid   (plan_valid),
        .plan_ready   (plan_ready),
        .plan         (plan),
        .cfg          (cfg),
        .rd_idx       (rd_idx),
        .rd_byte      (rd_byte),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_byte       (out_byte),
        .m_has_byte   (has_byte),
        .m_run_last   (m_tlast),
        .m_stream_end (stream_end),
        .m_total      (total)
    );

    assign m_tdata = {total, out_byte};
    assign m_tuser = {stream_end, has_byte};

endmodule

`default_nettype wire

// File: hw/rtl/sfr_checker.sv
// sfr_checker: port-level assertions for stream_find_replace, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module sfr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser,
    input wire logic        pready
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // End of text is always the last beat of its run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("stream_end without run_last");

    // A beat without a byte is only the bare end marker, with a zero byte
    a_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1] && (m_tdata[7:0] == 8'h00))
        else $error("bare beat outside end of text");

    // The byte count restarts after the end of a text
    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[1] |=> !m_tvalid || (m_tdata[39:8] <= 32'd1))
        else $error("total length did not restart");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

`default_nettype wire

// File: test/testbench.sv
// testbench: self-checking regression for stream_find_replace, with its own find-and-replace
// predictor held in a small scoreboard class. Depends on sfr_pkg and stream_find_replace.
`default_nettype none

module testbench;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 8;         // cycles waited after the last expected beat
    localparam int RANDOM_ITEMS  = 500;

    // One result beat, unpacked from m_tdata / m_tlast / m_tuser
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        run_last;
        logic        stream_end;
        logic [31:0] total_length;
    } out_beat_t;

    // Mirrors the block: register copies, window of pending bytes, byte count of the text.
    // take_byte() works out the beats one accepted input byte causes; check_beat() pops them.
    class find_replace_scoreboard;
        logic [STR_W-1:0] pattern;
        logic [STR_W-1:0] replace;
        logic [4:0]       pattern_len;
        logic [4:0]       replace_len;
        logic [7:0]       window [PATTERN_MAX];
        int               fill;
        logic [31:0]      emitted_count;
        out_beat_t        due_beats [$];
        int               errors;

        function new();
            pattern       = '0;
            replace       = '0;
            pattern_len   = 5'd1;
            replace_len   = 5'd0;
            fill          = 0;
            emitted_count = '0;
            errors        = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_LO:  pattern[63:0]   = value;
                REG_PATTERN_HI:  pattern[127:64] = value;
                REG_PATTERN_LEN: pattern_len     = value[4:0];
                REG_REPLACE_LO:  replace[63:0]   = value;
                REG_REPLACE_HI:  replace[127:64] = value;
                REG_REPLACE_LEN: replace_len     = value[4:0];
                default: ;
            endcase
        endfunction

        // Pattern length as the block uses it: zero counts as one, clamped to the window
        function int pattern_span();
            if (int'(pattern_len) == 0)
                return 1;
            if (int'(pattern_len) > PATTERN_MAX)
                return PATTERN_MAX;
            return int'(pattern_len);
        endfunction

        function void emit(logic [7:0] b, logic has);
            out_beat_t r;
            if (has)
                emitted_count = emitted_count + 1;
            r.out_byte     = has ? b : 8'h00;
            r.has_byte     = has;
            r.run_last     = 1'b0;
            r.stream_end   = 1'b0;
            r.total_length = emitted_count;
            due_beats.push_back(r);
        endfunction

        function void pass_oldest();
            emit(window[0], 1'b1);
            for (int i = 0; i < fill - 1; i++)
                window[i] = window[i + 1];
            fill--;
        endfunction

        function void take_byte(logic [7:0] b, logic eot);
            int        plen;
            int        rlen;
            int        first;
            bit        hit;
            out_beat_t tail;
            plen  = pattern_span();
            rlen  = (int'(replace_len) > REPLACE_MAX) ? REPLACE_MAX : int'(replace_len);
            first = due_beats.size();

            if (fill >= PATTERN_MAX)
                pass_oldest();
            window[fill] = b;
            fill++;

            if (fill == plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (window[i] != pattern[8*i +: 8])
                        hit = 1'b0;
                if (hit) begin
                    for (int i = 0; i < rlen; i++)
                        emit(replace[8*i +: 8], 1'b1);
                    fill = 0;
                end else begin
                    pass_oldest();
                end
            end else if (fill > plen) begin
                // pattern shrunk mid-text: drain one byte per beat, no match tried
                pass_oldest();
            end

            if (eot) begin
                for (int i = 0; i < fill; i++)
                    emit(window[i], 1'b1);
                fill = 0;
                if (due_beats.size() == first)
                    emit(8'h00, 1'b0);   // bare end marker
                tail = due_beats.pop_back();
                tail.stream_end = 1'b1;
                due_beats.push_back(tail);
                emitted_count = '0;
            end

            if (due_beats.size() > first) begin
                tail = due_beats.pop_back();
                tail.run_last = 1'b1;
                due_beats.push_back(tail);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            compare_field("out_byte",     32'(want.out_byte),   32'(got.out_byte));
            compare_field("has_byte",     32'(want.has_byte),   32'(got.has_byte));
            compare_field("run_last",     32'(want.run_last),   32'(got.run_last));
            compare_field("stream_end",   32'(want.stream_end), 32'(got.stream_end));
            compare_field("total_length", want.total_length,    got.total_length);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    find_replace_scoreboard sb = new();
    bit                     calm = 1'b0;   // phase with no idling on either side
    int                     cycles = 0;

    stream_find_replace dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("stream_find_replace regression: fail");
            $finish;
        end
    end

    // Result side: check every accepted beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat('{out_byte:     m_tdata[7:0],
                            has_byte:     m_tuser[0],
                            run_last:     m_tlast,
                            stream_end:   m_tuser[1],
                            total_length: m_tdata[39:8]});
    end

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver back-pressure
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if (!calm)
                    hold = pick_gap();
            end
        end
    end

    // One input beat; idles for the given gap first, returns once the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic eot, input int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b, eot);
    endtask

    // Hold the input off until every expected beat is out, then let the pipe settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int               sent;
        int               phase_left;
        int               text_left;
        int               span;
        int               n;
        logic [7:0]       piece [$];
        logic [7:0]       c0;
        logic [7:0]       c1;
        logic [STR_W-1:0] pat;
        logic [4:0]       plen_w;
        logic [4:0]       rlen_w;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: one-byte pattern 00, empty replacement, so 00 is deleted.
        // Last beat deleted leaves a bare end marker; a lone deleted byte too.
        send_beat(8'h00, 1'b0, 0);
        send_beat(8'hFF, 1'b0, 0);
        send_beat(8'h00, 1'b1, 0);
        send_beat(8'h00, 1'b1, 1);
        wait_drained();

        // Pattern length zero counts as one; oversized replacement clamps to 16 beats
        write_reg(REG_PATTERN_LO,  64'h0000_0000_0000_00A5);
        write_reg(REG_PATTERN_LEN, 64'd0);
        write_reg(REG_REPLACE_LO,  64'h00FF_5AA5_0FF0_8001);
        write_reg(REG_REPLACE_HI,  64'hFFFF_0000_7E81_C33C);
        write_reg(REG_REPLACE_LEN, 64'd31);
        send_beat(8'hA5, 1'b0, 0);
        send_beat(8'h5A, 1'b1, 0);
        wait_drained();

        // Oversized pattern clamps to 16; fill the window part way, then shrink the
        // pattern mid-text so the backlog drains one byte per beat
        write_reg(REG_PATTERN_LO,  64'hFEDC_BA98_7654_3210);
        write_reg(REG_PATTERN_HI,  64'h0123_4567_89AB_CDEF);
        write_reg(REG_PATTERN_LEN, 64'd31);
        write_reg(REG_REPLACE_LEN, 64'd0);
        for (int i = 0; i < 10; i++)
            send_beat(sb.pattern[8*i +: 8], 1'b0, 0);
        wait_drained();
        write_reg(REG_PATTERN_LEN, 64'd2);
        send_beat(8'h11, 1'b0, 0);
        send_beat(8'h22, 1'b0, 2);
        send_beat(8'h33, 1'b1, 0);
        wait_drained();

        // Random phases; each starts drained, with fresh settings. Texts run across phase
        // boundaries, so settings also change in the middle of a text.
        sent      = 0;
        text_left = $urandom_range(1, 40);
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       plen_w = 5'd1;
                1:       plen_w = 5'd16;
                2:       plen_w = 5'd0;
                3:       plen_w = 5'($urandom_range(17, 31));
                default: plen_w = 5'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       rlen_w = 5'd0;
                1:       rlen_w = 5'd16;
                2:       rlen_w = 5'($urandom_range(17, 31));
                default: rlen_w = 5'($urandom_range(0, 8));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                // two-letter alphabet gives overlapping and repeated matches
                c0 = 8'($urandom);
                c1 = 8'($urandom);
                for (int i = 0; i < 16; i++)
                    pat[8*i +: 8] = ($urandom_range(0, 1) == 1) ? c1 : c0;
            end else begin
                pat = {$urandom, $urandom, $urandom, $urandom};
            end
            write_reg(REG_PATTERN_LO,  pat[63:0]);
            write_reg(REG_PATTERN_HI,  pat[127:64]);
            write_reg(REG_PATTERN_LEN, {59'd0, plen_w});
            write_reg(REG_REPLACE_LO,  {$urandom, $urandom});
            write_reg(REG_REPLACE_HI,  {$urandom, $urandom});
            write_reg(REG_REPLACE_LEN, {59'd0, rlen_w});

            calm       = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(20, 60);
            span       = sb.pattern_span();
            while (phase_left > 0) begin
                piece.delete();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        for (int i = 0; i < span; i++)
                            piece.push_back(sb.pattern[8*i +: 8]);
                    end
                    4: begin
                        // broken occurrence, or at times a whole one when n reaches span
                        n = $urandom_range(1, span);
                        for (int i = 0; i < n; i++)
                            piece.push_back(sb.pattern[8*i +: 8]);
                    end
                    5: begin
                        n = $urandom_range(1, 6);
                        repeat (n) piece.push_back(8'($urandom));
                    end
                    default: begin
                        n = $urandom_range(1, 8);
                        repeat (n) piece.push_back(sb.pattern[8*$urandom_range(0, span - 1) +: 8]);
                    end
                endcase
                foreach (piece[i]) begin
                    text_left--;
                    send_beat(piece[i], text_left == 0, calm ? 0 : pick_gap());
                    if (text_left == 0)
                        text_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                                : $urandom_range(4, 40);
                    sent++;
                    phase_left--;
                end
            end
            wait_drained();
        end

        if (sb.errors == 0)
            $display("stream_find_replace regression: pass");
        else
            $display("stream_find_replace regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cfg.sv
hw/rtl/sfr_window.sv
hw/rtl/sfr_emit.sv
hw/rtl/stream_find_replace.sv
hw/rtl/sfr_checker.sv
test/testbench.sv
